### rtl/core/bwu_pkg.sv
// Shared types and constants of the breakpoint / watchpoint unit.
package bwu_pkg;

    localparam int AddrBits  = 16;
    // The address field carries 16 bits, so the map index never exceeds them.
    localparam int IdxBits   = (AddrBits < 16) ? AddrBits : 16;
    localparam int Space     = 1 << IdxBits;
    localparam int CountBits = 17;
    localparam int QDepth    = 2;
    localparam int QPtrBits  = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int QCntBits  = $clog2(QDepth + 1);

    localparam logic [1:0] WatchRead  = 2'b01;
    localparam logic [1:0] WatchWrite = 2'b10;

    typedef logic [IdxBits-1:0] t_idx;

    typedef enum logic [3:0] {
        OP_FETCH      = 4'd0,
        OP_ACCESS     = 4'd1,
        OP_ADD_BP     = 4'd2,
        OP_REMOVE_BP  = 4'd3,
        OP_TOGGLE_BP  = 4'd4,
        OP_CLEAR_BPS  = 4'd5,
        OP_SET_WATCH  = 4'd6,
        OP_CLEAR_WTCH = 4'd7,
        OP_SET_TRANS  = 4'd8,
        OP_CLR_TRANS  = 4'd9,
        OP_TIME_JUMP  = 4'd10,
        OP_CLEAR_HIT  = 4'd11,
        OP_ARM_SKIP   = 4'd12
    } t_op;

    typedef enum logic [2:0] {
        KIND_NONE      = 3'd0,
        KIND_BP        = 3'd1,
        KIND_WREAD     = 3'd2,
        KIND_WWRITE    = 3'd3,
        KIND_TRANSIENT = 3'd4
    } t_kind;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [15:0] address;
        logic [7:0]  data_value;
        logic        is_write;
        logic [1:0]  watch_mode;
        logic [3:0]  stop_tag;
    } t_in;

    typedef struct packed {
        logic                 stop_now;
        logic                 hit_present;
        logic [2:0]           hit_kind;
        logic [3:0]           hit_tag;
        logic [15:0]          hit_pc;
        logic [15:0]          hit_data_addr;
        logic [7:0]           hit_data;
        logic                 bp_at_addr;
        logic [1:0]           watch_at_addr;
        logic [CountBits-1:0] bp_total;
        logic [CountBits-1:0] watch_total;
    } t_out;

    // Decoded command word as it sits in the queue.
    typedef struct packed {
        logic       known;
        t_op        op;
        t_idx       addr;
        logic [7:0] data;
        logic       is_write;
        logic [1:0] watch_mode;
        logic [3:0] stop_tag;
    } t_cmd;

    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [3:0] tag;
        t_idx       pc;
        t_idx       daddr;
        logic [7:0] data;
    } t_hit;

endpackage

### rtl/core/breakpoint_watchpoint_unit.sv
// Top level of the breakpoint / watchpoint unit.
//
//   channel   ports                      handshake
//   command   i_start, i_cmd, o_busy     taken when i_start && !o_busy
//   result    o_done, o_res              one-cycle strobe, never held off
//
// In the execution side each command word first reads its map entry, then applies its update,
// and its result strobe o_done is registered from the update step.
// Whole-map clears then walk the map RAM, one entry at a time, over all 65536 entries.
// After reset the unit walks both map RAMs (all 65536 entries) with o_busy high.
// o_busy rises when the two-word command queue is full; results never stall.
module breakpoint_watchpoint_unit import bwu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_in  i_cmd,
    output logic o_busy,
    output logic o_done,
    output t_out o_res
);

    logic head_valid;
    t_cmd head;
    logic pop;
    logic init;

    bwu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_in         (i_cmd),
        .i_hold       (init),
        .i_pop        (pop),
        .o_busy       (o_busy),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    bwu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_init       (init),
        .o_done       (o_done),
        .o_res        (o_res)
    );

endmodule

### rtl/core/bwu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bwu_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/bwu_front.sv
// Command intake: decode each word and queue it for the execution side.
module bwu_front import bwu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_in  i_in,
    input  logic i_hold,
    input  logic i_pop,
    output logic o_busy,
    output logic o_head_valid,
    output t_cmd o_head
);

    t_cmd                r_q [QDepth];
    logic [QPtrBits-1:0] r_wp;
    logic [QPtrBits-1:0] r_rp;
    logic [QCntBits-1:0] r_cnt;
    logic [QPtrBits-1:0] n_wp;
    logic [QPtrBits-1:0] n_rp;
    logic                full;
    logic                push;
    t_cmd                dec;

    assign full         = (r_cnt == QCntBits'(QDepth));
    assign o_busy       = full | i_hold;
    assign push         = i_start & ~o_busy;
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_q[r_rp];

    // Classify: flag undefined opcodes, fold the address onto the map.
    always_comb begin
        dec.known      = (i_in.opcode <= OP_ARM_SKIP);
        dec.op         = t_op'(i_in.opcode);
        dec.addr       = i_in.address[IdxBits-1:0];
        dec.data       = i_in.data_value;
        dec.is_write   = i_in.is_write;
        dec.watch_mode = i_in.watch_mode;
        dec.stop_tag   = i_in.stop_tag;
    end

    assign n_wp = (r_wp == QPtrBits'(QDepth - 1)) ? '0 : r_wp + 1'b1;
    assign n_rp = (r_rp == QPtrBits'(QDepth - 1)) ? '0 : r_rp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
            unique case ({push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/core/bwu_back.sv
// Execution side: map memories, run-control state, hit record and result.
module bwu_back import bwu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_head_valid,
    input  t_cmd i_head,
    output logic o_pop,
    output logic o_init,
    output logic o_done,
    output t_out o_res
);

    typedef enum logic [1:0] {S_INIT, S_IDLE, S_EXEC, S_WIPE} t_state;

    t_state               r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    t_idx                 r_walk, n_walk;
    logic                 r_wipe_bp, n_wipe_bp;
    logic                 r_wipe_w, n_wipe_w;
    logic [CountBits-1:0] r_bp_count, n_bp_count;
    logic [CountBits-1:0] r_w_count, n_w_count;
    logic                 r_trans_on, n_trans_on;
    t_idx                 r_trans_addr, n_trans_addr;
    logic [3:0]           r_trans_code, n_trans_code;
    logic                 r_skip_on, n_skip_on;
    t_idx                 r_skip_addr, n_skip_addr;
    t_idx                 r_pc, n_pc;
    t_hit                 r_hit, n_hit;
    logic                 r_done, n_done;
    t_out                 r_res, n_res;

    logic                 bp_we, w_we;
    t_idx                 wa, raddr;
    logic                 bp_wd;
    logic [1:0]           w_wd;
    logic                 rd_bp;
    logic [1:0]           rd_w;

    bwu_ram #(.WIDTH(1), .DEPTH(Space)) u_bp_ram (
        .i_clk   (i_clk),
        .i_we    (bp_we),
        .i_waddr (wa),
        .i_wdata (bp_wd),
        .i_raddr (raddr),
        .o_rdata (rd_bp)
    );

    bwu_ram #(.WIDTH(2), .DEPTH(Space)) u_watch_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (wa),
        .i_wdata (w_wd),
        .i_raddr (raddr),
        .o_rdata (rd_w)
    );

    always_comb begin
        logic       new_bp;
        logic [1:0] new_w;
        logic       stop;
        logic       w_hit;

        n_state      = r_state;
        n_cmd        = r_cmd;
        n_walk       = r_walk;
        n_wipe_bp    = r_wipe_bp;
        n_wipe_w     = r_wipe_w;
        n_bp_count   = r_bp_count;
        n_w_count    = r_w_count;
        n_trans_on   = r_trans_on;
        n_trans_addr = r_trans_addr;
        n_trans_code = r_trans_code;
        n_skip_on    = r_skip_on;
        n_skip_addr  = r_skip_addr;
        n_pc         = r_pc;
        n_hit        = r_hit;
        n_done       = 1'b0;
        n_res        = r_res;
        o_pop        = 1'b0;
        bp_we        = 1'b0;
        w_we         = 1'b0;
        wa           = r_cmd.addr;
        bp_wd        = 1'b0;
        w_wd         = '0;
        raddr        = i_head.addr;
        new_bp       = rd_bp;
        new_w        = rd_w;
        stop         = 1'b0;
        w_hit        = r_cmd.is_write ? |(rd_w & WatchWrite) : |(rd_w & WatchRead);

        unique case (r_state)
            S_INIT: begin
                bp_we  = 1'b1;
                w_we   = 1'b1;
                wa     = r_walk;
                n_walk = r_walk + 1'b1;
                if (r_walk == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_head_valid) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_head;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                if (r_cmd.known) begin
                    unique case (r_cmd.op)
                        OP_FETCH: begin
                            if (r_hit.valid) begin
                                stop = 1'b1;
                            end else begin
                                n_pc      = r_cmd.addr;
                                n_skip_on = 1'b0;
                                // A pending skip at this pc swallows every stop once.
                                if (!(r_skip_on && r_cmd.addr == r_skip_addr)) begin
                                    if (r_trans_on && r_cmd.addr == r_trans_addr) begin
                                        n_trans_on = 1'b0;
                                        n_hit = '{valid: 1'b1, kind: KIND_TRANSIENT,
                                                  tag: r_trans_code, pc: r_cmd.addr,
                                                  daddr: '0, data: '0};
                                        stop  = 1'b1;
                                    end else if (rd_bp) begin
                                        n_hit = '{valid: 1'b1, kind: KIND_BP, tag: '0,
                                                  pc: r_cmd.addr, daddr: '0, data: '0};
                                        stop  = 1'b1;
                                    end
                                end
                            end
                        end
                        OP_ACCESS: begin
                            if (w_hit && !r_hit.valid) begin
                                n_hit = '{valid: 1'b1,
                                          kind: r_cmd.is_write ? KIND_WWRITE : KIND_WREAD,
                                          tag: '0, pc: r_pc, daddr: r_cmd.addr,
                                          data: r_cmd.data};
                            end
                        end
                        OP_ADD_BP: begin
                            new_bp = 1'b1;
                            bp_we  = 1'b1;
                            if (!rd_bp) begin
                                n_bp_count = r_bp_count + 1'b1;
                            end
                        end
                        OP_REMOVE_BP: begin
                            new_bp = 1'b0;
                            bp_we  = 1'b1;
                            if (rd_bp) begin
                                n_bp_count = r_bp_count - 1'b1;
                            end
                        end
                        OP_TOGGLE_BP: begin
                            new_bp     = ~rd_bp;
                            bp_we      = 1'b1;
                            n_bp_count = rd_bp ? r_bp_count - 1'b1 : r_bp_count + 1'b1;
                        end
                        OP_CLEAR_BPS: begin
                            new_bp     = 1'b0;
                            n_bp_count = '0;
                            n_wipe_bp  = 1'b1;
                            n_wipe_w   = 1'b0;
                            n_walk     = '0;
                            n_done     = 1'b0;
                            n_state    = S_WIPE;
                        end
                        OP_SET_WATCH: begin
                            new_w = r_cmd.watch_mode;
                            w_we  = 1'b1;
                            if (rd_w == '0 && r_cmd.watch_mode != '0) begin
                                n_w_count = r_w_count + 1'b1;
                            end else if (rd_w != '0 && r_cmd.watch_mode == '0) begin
                                n_w_count = r_w_count - 1'b1;
                            end
                        end
                        OP_CLEAR_WTCH: begin
                            new_w     = '0;
                            n_w_count = '0;
                            n_wipe_bp = 1'b0;
                            n_wipe_w  = 1'b1;
                            n_walk    = '0;
                            n_done    = 1'b0;
                            n_state   = S_WIPE;
                        end
                        OP_SET_TRANS: begin
                            n_trans_addr = r_cmd.addr;
                            n_trans_code = r_cmd.stop_tag;
                            n_trans_on   = 1'b1;
                        end
                        OP_CLR_TRANS: begin
                            n_trans_on = 1'b0;
                        end
                        OP_TIME_JUMP: begin
                            n_trans_on  = 1'b0;
                            n_skip_on   = 1'b0;
                            n_skip_addr = '0;
                            n_pc        = '0;
                            n_hit       = '0;
                        end
                        OP_CLEAR_HIT: begin
                            n_hit = '0;
                        end
                        OP_ARM_SKIP: begin
                            n_skip_on   = 1'b1;
                            n_skip_addr = r_cmd.addr;
                        end
                        default: begin
                        end
                    endcase
                end
                bp_wd = new_bp;
                w_wd  = new_w;
                n_res = '{stop_now:      stop,
                          hit_present:   n_hit.valid,
                          hit_kind:      n_hit.kind,
                          hit_tag:       n_hit.tag,
                          hit_pc:        16'(n_hit.pc),
                          hit_data_addr: 16'(n_hit.daddr),
                          hit_data:      n_hit.data,
                          bp_at_addr:    new_bp,
                          watch_at_addr: new_w,
                          bp_total:      n_bp_count,
                          watch_total:   n_w_count};
            end
            S_WIPE: begin
                // Walk the map being cleared; the result is already staged.
                bp_we  = r_wipe_bp;
                w_we   = r_wipe_w;
                wa     = r_walk;
                n_walk = r_walk + 1'b1;
                if (r_walk == '1) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_walk       <= '0;
            r_wipe_bp    <= 1'b0;
            r_wipe_w     <= 1'b0;
            r_bp_count   <= '0;
            r_w_count    <= '0;
            r_trans_on   <= 1'b0;
            r_trans_addr <= '0;
            r_trans_code <= '0;
            r_skip_on    <= 1'b0;
            r_skip_addr  <= '0;
            r_pc         <= '0;
            r_hit        <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_walk       <= n_walk;
            r_wipe_bp    <= n_wipe_bp;
            r_wipe_w     <= n_wipe_w;
            r_bp_count   <= n_bp_count;
            r_w_count    <= n_w_count;
            r_trans_on   <= n_trans_on;
            r_trans_addr <= n_trans_addr;
            r_trans_code <= n_trans_code;
            r_skip_on    <= n_skip_on;
            r_skip_addr  <= n_skip_addr;
            r_pc         <= n_pc;
            r_hit        <= n_hit;
            r_done       <= n_done;
        end
        r_cmd <= n_cmd;
        r_res <= n_res;
    end

    assign o_init = (r_state == S_INIT);
    assign o_done = r_done;
    assign o_res  = r_res;

    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_state) == S_EXEC) || ($past(r_state) == S_WIPE))
        else $error("result strobe without a finished command");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_head_valid && (r_state == S_IDLE))
        else $error("queue popped while empty or busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bp_count <= CountBits'(Space)) && (r_w_count <= CountBits'(Space)))
        else $error("entry count beyond map size");

    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_hit.valid |-> (r_hit.kind == KIND_NONE) && (r_hit.pc == '0)
                         && (r_hit.daddr == '0) && (r_hit.data == '0))
        else $error("stale hit fields with no hit latched");

endmodule

### tb/tb.sv
// Self-checking testbench of the breakpoint / watchpoint unit: directed table, then random words.
module tb;
    import bwu_pkg::*;

    localparam int HalfPeriod     = 6;
    localparam int ResetCycles    = 9;
    localparam int RandomWords    = 1430;
    localparam int DrainCycles    = 16;
    localparam int RunLimit       = 12 * 3_000_000;
    localparam int MapClearBudget = 6;
    localparam int HotCount       = 8;

    localparam logic [3:0]  FirstUnusedOp = 4'd13;
    localparam logic [3:0]  LastUnusedOp  = 4'd15;
    localparam logic [15:0] TopAddr       = 16'hFFFF;
    localparam logic [1:0]  WatchNone     = 2'b00;
    localparam logic [1:0]  WatchBoth     = WatchRead | WatchWrite;

    typedef struct {
        t_in  word;
        bit   typed;
        t_out want;
    } t_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_in  i_cmd   = '0;
    logic o_busy;
    logic o_done;
    t_out o_res;

    // Shadow of the debug state
    bit          brk_set    [Space];
    bit [1:0]    watch_mask [Space];
    int unsigned brk_total_q;
    int unsigned watch_total_q;
    bit          stop_armed;
    t_idx        stop_pc   = '0;
    logic [3:0]  stop_code = '0;
    bit          skip_armed;
    t_idx        skip_pc   = '0;
    t_idx        last_pc   = '0;
    t_hit        latched = '0;

    t_row plan[$];
    t_out pending_reports[$];
    int   mismatches  = 0;
    int   burst_left  = 0;
    int   clears_left = MapClearBudget;
    bit   fetch_follows = 1'b0;
    t_idx follow_pc;
    t_idx hot_addr [HotCount];

    breakpoint_watchpoint_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_cmd  (i_cmd),
        .o_busy (o_busy),
        .o_done (o_done),
        .o_res  (o_res)
    );

    always begin
        #HalfPeriod i_clk = 1'b1;
        #HalfPeriod i_clk = 1'b0;
    end

    function automatic t_out run_control_step(t_in w);
        t_out r;
        t_idx a;
        int   i;
        a = w.address;
        r = '0;
        case (w.opcode)
            OP_FETCH: begin
                if (latched.valid) begin
                    r.stop_now = 1'b1;
                end else begin
                    last_pc = a;
                    if (skip_armed && a == skip_pc) begin
                        skip_armed = 1'b0;
                    end else begin
                        skip_armed = 1'b0;
                        if (stop_armed && a == stop_pc) begin
                            stop_armed = 1'b0;
                            latched = '{valid: 1'b1, kind: KIND_TRANSIENT, tag: stop_code,
                                        pc: a, daddr: '0, data: '0};
                            r.stop_now = 1'b1;
                        end else if (brk_set[a]) begin
                            latched = '{valid: 1'b1, kind: KIND_BP, tag: '0,
                                        pc: a, daddr: '0, data: '0};
                            r.stop_now = 1'b1;
                        end
                    end
                end
            end
            OP_ACCESS: begin
                if (!latched.valid &&
                    (watch_mask[a] & (w.is_write ? WatchWrite : WatchRead)) != WatchNone) begin
                    latched = '{valid: 1'b1, kind: w.is_write ? KIND_WWRITE : KIND_WREAD,
                                tag: '0, pc: last_pc, daddr: a, data: w.data_value};
                end
            end
            OP_ADD_BP: begin
                if (!brk_set[a]) begin
                    brk_set[a] = 1'b1;
                    brk_total_q++;
                end
            end
            OP_REMOVE_BP: begin
                if (brk_set[a]) begin
                    brk_set[a] = 1'b0;
                    brk_total_q--;
                end
            end
            OP_TOGGLE_BP: begin
                if (brk_set[a]) brk_total_q--;
                else brk_total_q++;
                brk_set[a] = !brk_set[a];
            end
            OP_CLEAR_BPS: begin
                for (i = 0; i < Space; i++) brk_set[i] = 1'b0;
                brk_total_q = 0;
            end
            OP_SET_WATCH: begin
                if (watch_mask[a] == WatchNone && w.watch_mode != WatchNone) watch_total_q++;
                else if (watch_mask[a] != WatchNone && w.watch_mode == WatchNone) watch_total_q--;
                watch_mask[a] = w.watch_mode;
            end
            OP_CLEAR_WTCH: begin
                for (i = 0; i < Space; i++) watch_mask[i] = WatchNone;
                watch_total_q = 0;
            end
            OP_SET_TRANS: begin
                stop_pc    = a;
                stop_code  = w.stop_tag;
                stop_armed = 1'b1;
            end
            OP_CLR_TRANS: stop_armed = 1'b0;
            OP_TIME_JUMP: begin
                stop_armed = 1'b0;
                skip_armed = 1'b0;
                skip_pc    = '0;
                last_pc    = '0;
                latched    = '0;
            end
            OP_CLEAR_HIT: latched = '0;
            OP_ARM_SKIP: begin
                skip_armed = 1'b1;
                skip_pc    = a;
            end
            default: ;
        endcase
        r.hit_present = latched.valid;
        if (latched.valid) begin
            r.hit_kind      = latched.kind;
            r.hit_tag       = latched.tag;
            r.hit_pc        = latched.pc;
            r.hit_data_addr = latched.daddr;
            r.hit_data      = latched.data;
        end
        r.bp_at_addr    = brk_set[a];
        r.watch_at_addr = watch_mask[a];
        r.bp_total      = CountBits'(brk_total_q);
        r.watch_total   = CountBits'(watch_total_q);
        return r;
    endfunction

    function automatic t_in word_of(logic [3:0] op, logic [15:0] a, logic [7:0] d,
                                    logic wr, logic [1:0] mode, logic [3:0] tag);
        t_in w;
        w = '{opcode: op, address: a, data_value: d, is_write: wr,
              watch_mode: mode, stop_tag: tag};
        return w;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(t_in w, bit typed, t_out want);
        t_row row;
        row  = '{word: w, typed: typed, want: want};
        plan = {plan, row};
    endfunction

    // Mostly hit a small set of addresses so entries collide
    function automatic t_idx pick_addr();
        if ($urandom_range(0, 4) == 0) return t_idx'($urandom_range(0, Space - 1));
        return hot_addr[$urandom_range(0, HotCount - 1)];
    endfunction

    function automatic t_in random_word();
        t_in w;
        int  pick;
        w = word_of(OP_FETCH, pick_addr(), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                    4'($urandom_range(0, 15)));
        // After arming a skip or a transient, usually fetch right at that pc
        if (fetch_follows) begin
            fetch_follows = 1'b0;
            if ($urandom_range(0, 9) < 7) begin
                w.address = follow_pc;
                return w;
            end
        end
        pick = $urandom_range(0, 99);
        if (latched.valid && pick < 25)
            w.opcode = ($urandom_range(0, 7) == 0) ? OP_TIME_JUMP : OP_CLEAR_HIT;
        else if (pick < 50) w.opcode = OP_FETCH;
        else if (pick < 66) w.opcode = OP_ACCESS;
        else if (pick < 72) w.opcode = OP_ADD_BP;
        else if (pick < 76) w.opcode = OP_REMOVE_BP;
        else if (pick < 80) w.opcode = OP_TOGGLE_BP;
        else if (pick < 87) w.opcode = OP_SET_WATCH;
        else if (pick < 91) w.opcode = OP_SET_TRANS;
        else if (pick < 93) w.opcode = OP_CLR_TRANS;
        else if (pick < 94) w.opcode = OP_TIME_JUMP;
        else if (pick < 97) w.opcode = OP_ARM_SKIP;
        else if (pick < 98) w.opcode = OP_CLEAR_HIT;
        else if (pick < 99) w.opcode = 4'($urandom_range(FirstUnusedOp, LastUnusedOp));
        else if (clears_left > 0) begin
            // Whole-map clears walk the map, so keep them rare
            clears_left--;
            w.opcode = $urandom_range(0, 1) ? OP_CLEAR_BPS : OP_CLEAR_WTCH;
        end
        if (w.opcode == OP_SET_TRANS || w.opcode == OP_ARM_SKIP) begin
            fetch_follows = 1'b1;
            follow_pc     = w.address;
        end
        return w;
    endfunction

    task automatic send_word(t_in w, bit typed, t_out want);
        t_out predicted;
        if (burst_left == 0) begin
            i_start <= 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(4, 24) : $urandom_range(1, 3))
                @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                      : $urandom_range(1, 8);
        end
        i_start <= 1'b1;
        i_cmd   <= w;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        burst_left--;
        predicted = run_control_step(w);
        if (typed) predicted = want;
        pending_reports = {pending_reports, predicted};
    endtask

    task automatic note_diff(string field, logic [16:0] want, logic [16:0] got);
        $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
        mismatches++;
    endtask

    task automatic check_report(t_out want, t_out got);
        if (got.stop_now !== want.stop_now) note_diff("stop_now", want.stop_now, got.stop_now);
        if (got.hit_present !== want.hit_present)
            note_diff("hit_present", want.hit_present, got.hit_present);
        if (got.hit_kind !== want.hit_kind) note_diff("hit_kind", want.hit_kind, got.hit_kind);
        if (got.hit_tag !== want.hit_tag) note_diff("hit_tag", want.hit_tag, got.hit_tag);
        if (got.hit_pc !== want.hit_pc) note_diff("hit_pc", want.hit_pc, got.hit_pc);
        if (got.hit_data_addr !== want.hit_data_addr)
            note_diff("hit_data_addr", want.hit_data_addr, got.hit_data_addr);
        if (got.hit_data !== want.hit_data) note_diff("hit_data", want.hit_data, got.hit_data);
        if (got.bp_at_addr !== want.bp_at_addr)
            note_diff("bp_at_addr", want.bp_at_addr, got.bp_at_addr);
        if (got.watch_at_addr !== want.watch_at_addr)
            note_diff("watch_at_addr", want.watch_at_addr, got.watch_at_addr);
        if (got.bp_total !== want.bp_total) note_diff("bp_total", want.bp_total, got.bp_total);
        if (got.watch_total !== want.watch_total)
            note_diff("watch_total", want.watch_total, got.watch_total);
    endtask

    always @(posedge i_clk) begin
        if (o_done === 1'b1) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: report with none expected, actual %p", $time, o_res);
                mismatches++;
            end else begin
                check_report(pending_reports.pop_front(), o_res);
            end
        end
    end

    initial begin
        #(RunLimit);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        t_out one_bp;
        int   k;
        one_bp            = '0;
        one_bp.bp_at_addr = 1'b1;
        one_bp.bp_total   = CountBits'(1);
        hot_addr[0] = 16'h0000;
        hot_addr[1] = TopAddr;
        hot_addr[2] = 16'h8000;
        hot_addr[3] = 16'h00FF;
        hot_addr[4] = 16'h0200;
        for (k = 5; k < HotCount; k++) hot_addr[k] = t_idx'($urandom_range(0, Space - 1));

        add_row(word_of(OP_FETCH, 16'h0000, 8'h00, 1'b0, WatchNone, 4'h0), 1'b1, '0);
        add_row(word_of(LastUnusedOp, TopAddr, 8'hFF, 1'b1, WatchBoth, 4'hF), 1'b1, '0);
        add_row(word_of(OP_ADD_BP, TopAddr, 8'h00, 1'b0, WatchNone, 4'h0), 1'b1, one_bp);
        add_row(word_of(OP_ADD_BP, TopAddr, 8'h00, 1'b0, WatchNone, 4'h0), 1'b0, '0);
        add_row(word_of(OP_TOGGLE_BP, 16'h0000, 8'h00, 1'b0, WatchNone, 4'h0), 1'b0, '0);
        add_row(word_of(OP_REMOVE_BP, 16'h1234, 8'h00, 1'b0, WatchNone, 4'h0), 1'b0, '0);
        add_row(word_of(OP_SET_WATCH, 16'h8000, 8'h00, 1'b0, WatchBoth, 4'h0), 1'b0, '0);
        add_row(word_of(OP_SET_WATCH, 16'h8000, 8'h00, 1'b0, WatchRead, 4'h0), 1'b0, '0);
        add_row(word_of(OP_ACCESS, 16'h8000, 8'h3C, 1'b1, WatchNone, 4'h0), 1'b0, '0);
        add_row(word_of(OP_ACCESS, 16'h8000, 8'hA5, 1'b0, WatchNone, 4'h0), 1'b0, '0);
        add_row(word_of(OP_FETCH, 16'h0100, 8'h00, 1'b0, WatchNone, 4'h0), 1'b0, '0);
        add_row(word_of(OP_CLEAR_HIT, 16'h0100, 8'h00, 1'b0, WatchNone, 4'h0), 1'b0, '0);
        add_row(word_of(OP_SET_TRANS, 16'h0200, 8'h00, 1'b0, WatchNone, 4'hF), 1'b0, '0);
        add_row(word_of(OP_ARM_SKIP, 16'h0200, 8'h00, 1'b0, WatchNone, 4'h0), 1'b0, '0);
        add_row(word_of(OP_FETCH, 16'h0200, 8'h00, 1'b0, WatchNone, 4'h0), 1'b0, '0);
        add_row(word_of(OP_FETCH, 16'h0200, 8'h00, 1'b0, WatchNone, 4'h0), 1'b0, '0);
        add_row(word_of(OP_CLEAR_HIT, 16'h0200, 8'h00, 1'b0, WatchNone, 4'h0), 1'b0, '0);
        add_row(word_of(OP_FETCH, TopAddr, 8'h00, 1'b0, WatchNone, 4'h0), 1'b0, '0);
        add_row(word_of(OP_TIME_JUMP, 16'h0000, 8'h00, 1'b0, WatchNone, 4'h0), 1'b0, '0);
        add_row(word_of(OP_SET_WATCH, 16'h00FF, 8'h00, 1'b0, WatchWrite, 4'h0), 1'b0, '0);
        add_row(word_of(OP_ACCESS, 16'h00FF, 8'hFF, 1'b1, WatchNone, 4'h0), 1'b0, '0);
        add_row(word_of(OP_CLEAR_HIT, 16'h00FF, 8'h00, 1'b0, WatchNone, 4'h0), 1'b0, '0);
        add_row(word_of(OP_SET_TRANS, 16'h0300, 8'h00, 1'b0, WatchNone, 4'h5), 1'b0, '0);
        add_row(word_of(OP_CLR_TRANS, 16'h0300, 8'h00, 1'b0, WatchNone, 4'h0), 1'b0, '0);
        add_row(word_of(OP_FETCH, 16'h0300, 8'h00, 1'b0, WatchNone, 4'h0), 1'b0, '0);
        add_row(word_of(OP_SET_WATCH, 16'h8000, 8'h00, 1'b0, WatchNone, 4'h0), 1'b0, '0);
        add_row(word_of(OP_CLEAR_BPS, TopAddr, 8'h00, 1'b0, WatchNone, 4'h0), 1'b0, '0);
        add_row(word_of(OP_CLEAR_WTCH, 16'h00FF, 8'h00, 1'b0, WatchNone, 4'h0), 1'b0, '0);

        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[row_idx]) send_word(plan[row_idx].word, plan[row_idx].typed,
                                          plan[row_idx].want);
        repeat (RandomWords) send_word(random_word(), 1'b0, '0);
        i_start <= 1'b0;

        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatches == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

endmodule
